// ===== rtl/lbp3_pkg.sv =====
// Shared types and constants for the 3x3 local binary pattern unit.
package lbp3_pkg;

   // Build-time defaults
   localparam int MAX_WIDTH_DEFAULT = 4096;

   // Field widths
   localparam int PIXEL_W  = 8;
   localparam int CODE_W   = 8;
   localparam int CCOL_W   = 12;
   localparam int ROW_W    = 16;
   localparam int IMG_W_W  = 13;
   localparam int CSR_W    = 16;
   localparam int CMP_W    = 17;
   localparam int RSP_DATA_W = 40;

   // Register reset values and the smallest usable dimension
   localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RESET  = 13'd640;
   localparam logic [ROW_W-1:0]   IMAGE_HEIGHT_RESET = 16'd480;
   localparam logic [CMP_W-1:0]   MIN_DIM            = 17'd3;

   // Register indexes
   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // One window column, top row to bottom row
   typedef struct packed {
      logic [PIXEL_W-1:0] top;
      logic [PIXEL_W-1:0] mid;
      logic [PIXEL_W-1:0] bot;
   } column_type;

endpackage

// ===== rtl/lbp3_line_store.sv =====
// Line store memory: each entry holds the upper and middle row pixels of one column.
module lbp3_line_store
   import lbp3_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
   output logic [PIXEL_W-1:0]            rd_upper,
   output logic [PIXEL_W-1:0]            rd_middle,
   input  logic                          wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
   input  logic [PIXEL_W-1:0]            wr_upper,
   input  logic [PIXEL_W-1:0]            wr_middle
);

   logic [2*PIXEL_W-1:0] mem [MAX_WIDTH];
   logic [2*PIXEL_W-1:0] rd_data_ff;

   // Write back the shifted column pair
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_upper, wr_middle};
      end
   end

   // Registered read, held while no new read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_upper  = rd_data_ff[2*PIXEL_W-1:PIXEL_W];
   assign rd_middle = rd_data_ff[PIXEL_W-1:0];

endmodule

// ===== rtl/lbp3_window.sv =====
// Two-column window registers and the eight neighbour comparisons.
module lbp3_window
   import lbp3_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               shift,
   input  column_type         new_col,
   output logic [CODE_W-1:0]  code
);

   column_type prev1_ff, prev1_in;
   column_type prev2_ff, prev2_in;
   logic [PIXEL_W-1:0] centre;

   // Advance the window by one column
   always_comb begin
      prev1_in = prev1_ff;
      prev2_in = prev2_ff;
      if (shift) begin
         prev1_in = new_col;
         prev2_in = prev1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev1_ff <= '0;
         prev2_ff <= '0;
      end else begin
         prev1_ff <= prev1_in;
         prev2_ff <= prev2_in;
      end
   end

   // Compare each neighbour against the centre, clockwise from top-left
   assign centre = prev1_ff.mid;
   always_comb begin
      code[7] = (prev2_ff.top >= centre);
      code[6] = (prev1_ff.top >= centre);
      code[5] = (new_col.top  >= centre);
      code[4] = (new_col.mid  >= centre);
      code[3] = (new_col.bot  >= centre);
      code[2] = (prev1_ff.bot >= centre);
      code[1] = (prev2_ff.bot >= centre);
      code[0] = (prev2_ff.mid >= centre);
   end

endmodule

// ===== rtl/lbp_3x3_texture_code_unit.sv =====
// Top level of the streaming 3x3 local binary pattern unit.
// Pixels enter in raster order, one per clock at full rate; each accepted pixel
// issues one read of the line store (one memory with a registered read port),
// and the code of the centre it completes passes from stage one into the output
// register. Border centres give no beat. The input stalls only while an interior
// code waits unaccepted in the output register and the pixel in stage one also
// completes an interior centre. Consecutive pixels always address different line
// store entries, so the write-back of one pixel never collides with the read of
// the next. The line store needs no clearing after reset; image_width and
// image_height should be written only while the unit is idle.
module lbp_3x3_texture_code_unit
   import lbp3_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // Pixel input
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] pixel
   // Code output
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [7:0] pattern_code, [19:8] centre_column,
                                               // [35:20] centre_row, [39:36] zero
   output logic                   rsp_tlast,   // frame_last
   // Register writes
   input  logic                   csr_write_enable,
   input  logic [0:0]             csr_index,
   input  logic [CSR_W-1:0]       csr_write_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);

   // Configuration registers
   logic [IMG_W_W-1:0] image_width_ff, image_width_in;
   logic [ROW_W-1:0]   image_height_ff, image_height_in;
   logic [CMP_W-1:0]   eff_width, eff_height;

   // Position of the next pixel
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic               col_wrap, row_wrap;

   // Stage one: pixel waiting for its line store data
   logic               s1_valid_ff, s1_valid_in;
   logic [PIXEL_W-1:0] s1_pixel_ff;
   logic [COL_W-1:0]   s1_col_ff;
   logic               s1_hit_ff;
   logic               s1_last_ff;
   logic [CCOL_W-1:0]  s1_ccol_ff;
   logic [ROW_W-1:0]   s1_crow_ff;
   logic               s1_advance;

   // Output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]  rsp_code_ff;
   logic [CCOL_W-1:0]  rsp_ccol_ff;
   logic [ROW_W-1:0]   rsp_crow_ff;
   logic               rsp_last_ff;

   logic               req_accept;
   logic [PIXEL_W-1:0] upper_rd, middle_rd;
   column_type         new_col;
   logic [CODE_W-1:0]  code;

   // Register writes
   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  image_width_in  = csr_write_data[IMG_W_W-1:0];
            CSR_IMAGE_HEIGHT: image_height_in = csr_write_data[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= IMAGE_WIDTH_RESET;
         image_height_ff <= IMAGE_HEIGHT_RESET;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
      end
   end

   // Clamp the dimensions to their usable range
   always_comb begin
      eff_width = CMP_W'(image_width_ff);
      if (eff_width < MIN_DIM) begin
         eff_width = MIN_DIM;
      end else if (eff_width > CMP_W'(MAX_WIDTH)) begin
         eff_width = CMP_W'(MAX_WIDTH);
      end
      eff_height = CMP_W'(image_height_ff);
      if (eff_height < MIN_DIM) begin
         eff_height = MIN_DIM;
      end
   end

   // Handshake
   assign s1_advance = s1_valid_ff && (!s1_hit_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_accept = req_tvalid && req_tready;

   // Advance the raster position on each accepted pixel
   assign col_wrap = (CMP_W'(col_ff) + CMP_W'(1)) >= eff_width;
   assign row_wrap = (CMP_W'(row_ff) + CMP_W'(1)) >= eff_height;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_accept) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Stage one control
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Capture the pixel and its result tags while the line store is read
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pixel_ff <= req_tdata;
         s1_col_ff   <= col_ff;
         s1_hit_ff   <= (CMP_W'(col_ff) >= CMP_W'(2)) && (row_ff >= ROW_W'(2));
         s1_last_ff  <= col_wrap && row_wrap;
         s1_ccol_ff  <= CCOL_W'(col_ff - COL_W'(1));
         s1_crow_ff  <= row_ff - ROW_W'(1);
      end
   end

   // Line store: read on accept, write back when stage one retires
   lbp3_line_store #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_store (
      .clock     (clock),
      .rd_en     (req_accept),
      .rd_addr   (col_ff),
      .rd_upper  (upper_rd),
      .rd_middle (middle_rd),
      .wr_en     (s1_advance),
      .wr_addr   (s1_col_ff),
      .wr_upper  (middle_rd),
      .wr_middle (s1_pixel_ff)
   );

   assign new_col.top = upper_rd;
   assign new_col.mid = middle_rd;
   assign new_col.bot = s1_pixel_ff;

   lbp3_window u_window (
      .clock   (clock),
      .reset   (reset),
      .shift   (s1_advance),
      .new_col (new_col),
      .code    (code)
   );

   // Output register: load on an interior centre, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance && s1_hit_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_hit_ff) begin
         rsp_code_ff <= code;
         rsp_ccol_ff <= s1_ccol_ff;
         rsp_crow_ff <= s1_crow_ff;
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_crow_ff, rsp_ccol_ff, rsp_code_ff});
   assign rsp_tlast  = rsp_last_ff;

   // A code never overwrites an unaccepted beat
   assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_hit_ff) |-> (!rsp_valid_ff || rsp_tready))
      else $error("output register overrun");

   // Input stalls only behind a stage one pixel
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && s1_hit_ff && rsp_valid_ff))
      else $error("input stalled without cause");

   // A taken beat with no new code leaves the output empty
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_tready && !(s1_advance && s1_hit_ff)) |=> !rsp_valid_ff)
      else $error("output beat repeated");

   // Interior centres never sit in column or row zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ccol_ff != '0 && rsp_crow_ff != '0))
      else $error("border centre emitted");

endmodule

// ===== tb/lbp_3x3_texture_code_unit_test.sv =====
// Self-checking testbench for the streaming 3x3 local binary pattern unit.
module lbp_3x3_texture_code_unit_test;
   import lbp3_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_PIXELS = 560;
   localparam int unsigned DRAIN_CYCLES  = 8;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned CYCLE_LIMIT   = 100000;

   // One code beat as the unit should deliver it
   typedef struct packed {
      logic [CODE_W-1:0] pattern_code;
      logic [CCOL_W-1:0] centre_column;
      logic [ROW_W-1:0]  centre_row;
      logic              frame_last;
   } lbp_code_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_write_enable = 1'b0;
   logic [0:0]            csr_index = '0;
   logic [CSR_W-1:0]      csr_write_data = '0;

   // Stimulus and scoreboard
   logic [PIXEL_W-1:0] pixel_queue [$];
   lbp_code_type       expected_codes [$];
   int unsigned        pixels_accepted = 0;
   int unsigned        mismatches = 0;
   int unsigned        cycle_count = 0;
   int unsigned        tx_idle_pct = 0;
   int unsigned        rx_idle_pct = 0;
   int unsigned        hold_at_pixel = 32'hFFFF_FFFF;
   int unsigned        rx_hold_left = 0;
   logic               rx_hold_done = 1'b0;

   // Predictor state: registers, line stores, window and raster position
   logic [IMG_W_W-1:0] cfg_width = IMAGE_WIDTH_RESET;
   logic [ROW_W-1:0]   cfg_height = IMAGE_HEIGHT_RESET;
   logic [PIXEL_W-1:0] upper_row [MAX_WIDTH_DEFAULT];
   logic [PIXEL_W-1:0] middle_row [MAX_WIDTH_DEFAULT];
   column_type         left1 = '0;
   column_type         left2 = '0;
   int unsigned        col_pos = 0;
   int unsigned        row_pos = 0;

   lbp_3x3_texture_code_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tlast        (rsp_tlast),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Clamp the registers to the sizes the unit really uses
   function automatic int unsigned eff_width();
      if (cfg_width < 3) return 3;
      if (cfg_width > MAX_WIDTH_DEFAULT) return MAX_WIDTH_DEFAULT;
      return cfg_width;
   endfunction

   function automatic int unsigned eff_height();
      return (cfg_height < 3) ? 3 : cfg_height;
   endfunction

   // Pixels left until the raster position wraps to the next frame
   function automatic int unsigned pixels_to_frame_end();
      int unsigned row_rest;
      int unsigned rows_after;
      row_rest   = (col_pos >= eff_width()) ? 1 : eff_width() - col_pos;
      rows_after = (row_pos >= eff_height()) ? 0 : eff_height() - 1 - row_pos;
      return row_rest + rows_after * eff_width();
   endfunction

   // Advance the window by one pixel and queue the code it completes, if any
   function automatic void predict_pixel(input logic [PIXEL_W-1:0] pixel);
      int unsigned  slot;
      column_type   fresh;
      logic [7:0]   centre;
      lbp_code_type code;
      slot = col_pos % MAX_WIDTH_DEFAULT;
      fresh.top = upper_row[slot];
      fresh.mid = middle_row[slot];
      fresh.bot = pixel;
      if (row_pos >= 2 && col_pos >= 2) begin
         centre = left1.mid;
         // top-left first, clockwise round to the left neighbour
         code.pattern_code = {left2.top >= centre, left1.top >= centre, fresh.top >= centre,
                              fresh.mid >= centre, fresh.bot >= centre, left1.bot >= centre,
                              left2.bot >= centre, left2.mid >= centre};
         code.centre_column = CCOL_W'(col_pos - 1);
         code.centre_row    = ROW_W'(row_pos - 1);
         code.frame_last    = (col_pos + 1 >= eff_width()) && (row_pos + 1 >= eff_height());
         expected_codes.push_back(code);
      end
      upper_row[slot]  = fresh.mid;
      middle_row[slot] = pixel;
      left2 = left1;
      left1 = fresh;
      col_pos++;
      if (col_pos >= eff_width()) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= eff_height()) row_pos = 0;
      end
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // Pixel driver: hold a stalled beat, otherwise offer the next pixel or idle
   always @(posedge clock) begin : drive_pixels
      logic offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_pixel(req_tdata);
            void'(pixel_queue.pop_front());
            pixels_accepted <= pixels_accepted + 1;
         end
         if (req_tvalid && !req_tready) offer = 1'b1;
         else offer = (pixel_queue.size() != 0) && ($urandom_range(99) >= tx_idle_pct);
         req_tvalid <= offer;
         if (offer) req_tdata <= pixel_queue[0];
      end
   end

   // Count down one long back-pressure stretch once the trigger pixel is in
   always @(posedge clock) begin
      if (reset) begin
         rx_hold_left <= 0;
      end else if (rx_hold_left != 0) begin
         rx_hold_left <= rx_hold_left - 1;
      end else if (!rx_hold_done && pixels_accepted >= hold_at_pixel) begin
         rx_hold_left <= HOLD_CYCLES;
         rx_hold_done <= 1'b1;
      end
   end

   // Code receiver ready, idling at random
   always @(posedge clock) begin
      if (reset || rx_hold_left != 0) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // Compare every accepted code beat with the oldest expectation
   always @(posedge clock) begin : check_codes
      lbp_code_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_codes.size() == 0) begin
            $error("unexpected code beat: tdata %h tlast %b", rsp_tdata, rsp_tlast);
            mismatches++;
         end else begin
            want = expected_codes.pop_front();
            check_field("pattern_code", 16'(want.pattern_code), 16'(rsp_tdata[7:0]));
            check_field("centre_column", 16'(want.centre_column), 16'(rsp_tdata[19:8]));
            check_field("centre_row", want.centre_row, rsp_tdata[35:20]);
            check_field("frame_last", 16'(want.frame_last), 16'(rsp_tlast));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** lbp_3x3_texture_code_unit: FAILED **");
         $finish;
      end
   end

   task automatic set_idling(input int unsigned mode);
      case (mode)
         0: begin
            tx_idle_pct = 6;
            rx_idle_pct = 55;
         end
         1: begin
            tx_idle_pct = 55;
            rx_idle_pct = 6;
         end
         default: begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
      endcase
   endtask

   // Wait until every pixel is in and every code is out, then let the pipe settle
   task automatic wait_idle();
      while (pixel_queue.size() != 0 || req_tvalid || expected_codes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type index, input logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == CSR_IMAGE_WIDTH) cfg_width = value[IMG_W_W-1:0];
      else cfg_height = value;
   endtask

   // Queue random pixels, a quarter of them clustered so that ties are common
   task automatic queue_random(input int unsigned count);
      repeat (count) begin
         if ($urandom_range(3) == 0) pixel_queue.push_back(8'(100 + $urandom_range(3)));
         else pixel_queue.push_back(8'($urandom_range(255)));
      end
   endtask

   initial begin : stimulus
      logic [7:0]  corner_frames [18];
      int unsigned frame_pixels;
      int unsigned part;
      int unsigned spent;
      corner_frames = '{8'd0, 8'd255, 8'd128, 8'd127, 8'd128, 8'd129,
                        8'd255, 8'd0, 8'd128,
                        8'd254, 8'd254, 8'd254, 8'd254, 8'd255, 8'd255,
                        8'd254, 8'd254, 8'd254};
      spent = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      set_idling(0);

      // Sizes below the minimum act as 3x3; two back-to-back frames check the wrap
      write_register(CSR_IMAGE_WIDTH, 16'd0);
      write_register(CSR_IMAGE_HEIGHT, 16'd1);
      foreach (corner_frames[i]) pixel_queue.push_back(corner_frames[i]);
      wait_idle();

      // Random frames of small sizes, some resized partway through
      while (spent < RANDOM_PIXELS) begin
         set_idling(spent * 3 / RANDOM_PIXELS);
         case ($urandom_range(7))
            0: write_register(CSR_IMAGE_WIDTH, 16'($urandom_range(2)));
            1: write_register(CSR_IMAGE_WIDTH, 16'($urandom_range(40, 13)));
            default: write_register(CSR_IMAGE_WIDTH, 16'($urandom_range(12, 3)));
         endcase
         write_register(CSR_IMAGE_HEIGHT, 16'($urandom_range(8)));
         frame_pixels = pixels_to_frame_end();
         if (eff_width() >= 6 && $urandom_range(2) == 0) begin
            part = $urandom_range(frame_pixels - 1, 1);
            queue_random(part);
            spent += part;
            wait_idle();
            // never widen mid-frame: the upper rows would not be filled yet
            if ($urandom_range(1) == 0)
               write_register(CSR_IMAGE_WIDTH, 16'($urandom_range(eff_width())));
            else
               write_register(CSR_IMAGE_HEIGHT, 16'($urandom_range(eff_height() + 3)));
            frame_pixels = pixels_to_frame_end();
         end
         queue_random(frame_pixels);
         spent += frame_pixels;
         wait_idle();
      end

      // Oversized width clamps to the line store depth; shrink it partway through a row
      set_idling(2);
      write_register(CSR_IMAGE_WIDTH, 16'd8191);
      write_register(CSR_IMAGE_HEIGHT, 16'd3);
      queue_random(24);
      wait_idle();
      write_register(CSR_IMAGE_WIDTH, 16'd3);
      queue_random(pixels_to_frame_end());
      wait_idle();

      // Long receiver stall while the sender keeps offering pixels
      write_register(CSR_IMAGE_WIDTH, 16'd16);
      write_register(CSR_IMAGE_HEIGHT, 16'd8);
      hold_at_pixel = pixels_accepted + 40;
      queue_random(pixels_to_frame_end());
      wait_idle();

      // Tallest frame, cut short by a height write partway through
      write_register(CSR_IMAGE_WIDTH, 16'd3);
      write_register(CSR_IMAGE_HEIGHT, 16'd65535);
      queue_random(30);
      wait_idle();
      write_register(CSR_IMAGE_HEIGHT, 16'd12);
      queue_random(pixels_to_frame_end());
      wait_idle();

      if (mismatches == 0 && expected_codes.size() == 0)
         $display("** lbp_3x3_texture_code_unit: PASSED **");
      else
         $display("** lbp_3x3_texture_code_unit: FAILED **");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/lbp3_pkg.sv
rtl/lbp3_line_store.sv
rtl/lbp3_window.sv
rtl/lbp_3x3_texture_code_unit.sv
tb/lbp_3x3_texture_code_unit_test.sv
